/* design/apcat_pkg.sv */
// apcat_pkg: shared types and constants for the access point client association table
`default_nettype none
package apcat_pkg;

  localparam int AP_ENTRIES_DEF = 64;
  localparam int CPA_DEF        = 16;
  localparam int ADDR_W         = 48;
  localparam int SLOT_W         = 6;
  localparam int TOTAL_W        = 7;
  localparam int CTOT_W         = 5;

  localparam logic KIND_OBSERVE = 1'b0;
  localparam logic KIND_CLEAR   = 1'b1;

  typedef struct packed {
    logic              kind;
    logic [ADDR_W-1:0] bssid;
    logic              client_present;
    logic [ADDR_W-1:0] client_mac;
  } in_word_t;

  typedef struct packed {
    logic [SLOT_W-1:0]  ap_slot;
    logic               ap_added;
    logic               client_added;
    logic               ap_table_full;
    logic               client_list_full;
    logic [TOTAL_W-1:0] ap_total;
    logic [CTOT_W-1:0]  client_total;
  } out_word_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_AP_SCAN,
    ST_AP_DONE,
    ST_CNT_LOAD,
    ST_CL_SCAN,
    ST_CL_DONE,
    ST_RESULT
  } state_t;

  typedef struct packed {
    logic load;
    logic scan_en;
    logic scan_cl;
    logic ap_resolve;
    logic n_load;
    logic cl_resolve;
  } cmd_t;

  typedef struct packed {
    logic kind;
    logic found;
    logic ap_space;
    logic present;
    logic scan_done;
  } sts_t;

endpackage
`default_nettype wire

/* design/apcat_ctrl.sv */
// apcat_ctrl: sequencing state machine for lookup, insert and result
`default_nettype none
module apcat_ctrl
  import apcat_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic start,
  input  wire sts_t sts,
  output cmd_t      cmd,
  output logic      busy,
  output logic      out_valid
);

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          state_nxt = ST_DECODE;
        end
      end
      ST_DECODE: begin
        if (sts.kind == KIND_CLEAR) begin
          state_nxt = ST_RESULT;
        end else begin
          state_nxt = ST_AP_SCAN;
        end
      end
      ST_AP_SCAN: begin
        if (sts.scan_done) begin
          state_nxt = ST_AP_DONE;
        end
      end
      ST_AP_DONE: begin
        if (sts.found) begin
          state_nxt = ST_CNT_LOAD;
        end else if (sts.ap_space && sts.present) begin
          state_nxt = ST_CL_SCAN;
        end else begin
          state_nxt = ST_RESULT;
        end
      end
      ST_CNT_LOAD: begin
        if (sts.present) begin
          state_nxt = ST_CL_SCAN;
        end else begin
          state_nxt = ST_RESULT;
        end
      end
      ST_CL_SCAN: begin
        if (sts.scan_done) begin
          state_nxt = ST_CL_DONE;
        end
      end
      ST_CL_DONE: state_nxt = ST_RESULT;
      ST_RESULT:  state_nxt = ST_IDLE;
      default:    state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    busy      = 1'b1;
    out_valid = 1'b0;
    case (state_r)
      ST_IDLE: begin
        busy     = 1'b0;
        cmd.load = start;
      end
      ST_DECODE:   ;
      ST_AP_SCAN:  cmd.scan_en = 1'b1;
      ST_AP_DONE:  cmd.ap_resolve = 1'b1;
      ST_CNT_LOAD: cmd.n_load = 1'b1;
      ST_CL_SCAN: begin
        cmd.scan_en = 1'b1;
        cmd.scan_cl = 1'b1;
      end
      ST_CL_DONE:  cmd.cl_resolve = 1'b1;
      ST_RESULT:   out_valid = 1'b1;
      default:     busy = 1'b1;
    endcase
  end

`ifndef SYNTH
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held longer than one cycle");
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("block not busy after accepting a word");
`endif

endmodule
`default_nettype wire

/* design/apcat_dp.sv */
// apcat_dp: address stores, counters, scan unit and result registers
`default_nettype none
module apcat_dp
  import apcat_pkg::*;
#(
  parameter int AP_ENTRIES     = AP_ENTRIES_DEF,
  parameter int CLIENTS_PER_AP = CPA_DEF
)(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire in_word_t in_word,
  input  wire cmd_t     cmd,
  output sts_t          sts,
  output out_word_t     out_word
);

  localparam int AW   = $clog2(AP_ENTRIES);
  localparam int CNTW = $clog2(AP_ENTRIES + 1);
  localparam int NW   = $clog2(CLIENTS_PER_AP + 1);
  localparam int CAW  = $clog2(AP_ENTRIES * CLIENTS_PER_AP);
  localparam int SW   = (CNTW > NW) ? CNTW : NW;
  localparam int CL_DEPTH = AP_ENTRIES * CLIENTS_PER_AP;

  logic [ADDR_W-1:0] ap_mem  [AP_ENTRIES];
  logic [ADDR_W-1:0] cl_mem  [CL_DEPTH];
  logic [NW-1:0]     cnt_mem [AP_ENTRIES];

  in_word_t          in_r;
  logic [CNTW-1:0]   ap_count_r;
  logic [AW-1:0]     slot_r;
  logic [NW-1:0]     n_r;
  logic              found_r;
  logic              dup_r;
  logic              ap_added_r;
  logic              cl_added_r;
  logic              ap_full_r;
  logic              cl_full_r;
  logic [SW-1:0]     idx_r;
  logic [SW-1:0]     pend_idx_r;
  logic              pend_r;
  logic [ADDR_W-1:0] ap_rdata_r;
  logic [ADDR_W-1:0] cl_rdata_r;
  logic [NW-1:0]     cnt_rdata_r;

  logic [SW-1:0]     limit;
  logic [ADDR_W-1:0] key;
  logic [ADDR_W-1:0] rdata;
  logic              hit_now;
  logic              ap_space;
  logic              cl_space;
  logic              ap_we;
  logic              cl_we;
  logic              cnt_we;
  logic [AW-1:0]     cnt_waddr;
  logic [NW-1:0]     cnt_wdata;
  logic [CAW-1:0]    cl_base;
  logic [CAW-1:0]    cl_raddr;
  logic [CAW-1:0]    cl_waddr;

  assign ap_space  = ap_count_r < CNTW'(AP_ENTRIES);
  assign cl_space  = n_r < NW'(CLIENTS_PER_AP);
  assign limit     = cmd.scan_cl ? SW'(n_r) : SW'(ap_count_r);
  assign key       = cmd.scan_cl ? in_r.client_mac : in_r.bssid;
  assign rdata     = cmd.scan_cl ? cl_rdata_r : ap_rdata_r;
  assign hit_now   = cmd.scan_en && pend_r && (rdata == key);
  assign ap_we     = cmd.ap_resolve && !found_r && ap_space;
  assign cl_we     = cmd.cl_resolve && !dup_r && cl_space;
  assign cnt_we    = ap_we || cl_we;
  assign cnt_waddr = ap_we ? ap_count_r[AW-1:0] : slot_r;
  assign cnt_wdata = ap_we ? '0 : n_r + NW'(1);
  assign cl_base   = CAW'(slot_r) * CAW'(CLIENTS_PER_AP);
  assign cl_raddr  = cl_base + CAW'(idx_r);
  assign cl_waddr  = cl_base + CAW'(n_r);

  always_comb begin
    sts           = '0;
    sts.kind      = in_r.kind;
    sts.found     = found_r;
    sts.ap_space  = ap_space;
    sts.present   = in_r.client_present;
    sts.scan_done = hit_now || (idx_r >= limit);
  end

  // stores
  always_ff @(posedge clk) begin
    if (ap_we) begin
      ap_mem[ap_count_r[AW-1:0]] <= in_r.bssid;
    end
    ap_rdata_r <= ap_mem[idx_r[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (cl_we) begin
      cl_mem[cl_waddr] <= in_r.client_mac;
    end
    cl_rdata_r <= cl_mem[cl_raddr];
  end

  always_ff @(posedge clk) begin
    if (cnt_we) begin
      cnt_mem[cnt_waddr] <= cnt_wdata;
    end
    cnt_rdata_r <= cnt_mem[slot_r];
  end

  // scan unit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r  <= '0;
      pend_r <= 1'b0;
    end else if (cmd.scan_en) begin
      if (idx_r < limit) begin
        idx_r  <= idx_r + SW'(1);
        pend_r <= 1'b1;
      end else begin
        pend_r <= 1'b0;
      end
    end else begin
      idx_r  <= '0;
      pend_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    pend_idx_r <= idx_r;
  end

  // entry count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ap_count_r <= '0;
    end else if (cmd.load && (in_word.kind == KIND_CLEAR)) begin
      ap_count_r <= '0;
    end else if (ap_we) begin
      ap_count_r <= ap_count_r + CNTW'(1);
    end
  end

  // item register
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      in_r <= in_word;
    end
  end

  // result registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r     <= '0;
      n_r        <= '0;
      found_r    <= 1'b0;
      dup_r      <= 1'b0;
      ap_added_r <= 1'b0;
      cl_added_r <= 1'b0;
      ap_full_r  <= 1'b0;
      cl_full_r  <= 1'b0;
    end else if (cmd.load) begin
      slot_r     <= '0;
      n_r        <= '0;
      found_r    <= 1'b0;
      dup_r      <= 1'b0;
      ap_added_r <= 1'b0;
      cl_added_r <= 1'b0;
      ap_full_r  <= 1'b0;
      cl_full_r  <= 1'b0;
    end else begin
      if (hit_now) begin
        if (cmd.scan_cl) begin
          dup_r <= 1'b1;
        end else begin
          found_r <= 1'b1;
          slot_r  <= pend_idx_r[AW-1:0];
        end
      end
      if (cmd.ap_resolve && !found_r) begin
        if (ap_space) begin
          slot_r     <= ap_count_r[AW-1:0];
          ap_added_r <= 1'b1;
        end else begin
          ap_full_r <= 1'b1;
        end
      end
      if (cmd.n_load) begin
        n_r <= cnt_rdata_r;
      end
      if (cmd.cl_resolve && !dup_r) begin
        if (cl_space) begin
          n_r        <= n_r + NW'(1);
          cl_added_r <= 1'b1;
        end else begin
          cl_full_r <= 1'b1;
        end
      end
    end
  end

  always_comb begin
    out_word                  = '0;
    out_word.ap_slot          = SLOT_W'(slot_r);
    out_word.ap_added         = ap_added_r;
    out_word.client_added     = cl_added_r;
    out_word.ap_table_full    = ap_full_r;
    out_word.client_list_full = cl_full_r;
    out_word.ap_total         = TOTAL_W'(ap_count_r);
    out_word.client_total     = CTOT_W'(n_r);
  end

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    ap_count_r <= CNTW'(AP_ENTRIES))
    else $error("access point count beyond table size");
  a_list_bound: assert property (@(posedge clk) disable iff (!rst_n)
    n_r <= NW'(CLIENTS_PER_AP))
    else $error("client count beyond list size");
  a_add_or_full: assert property (@(posedge clk) disable iff (!rst_n)
    ap_added_r |-> !ap_full_r)
    else $error("access point both added and dropped");
  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.load && (in_word.kind == KIND_CLEAR)) |=> (ap_count_r == '0))
    else $error("clear word left entries in the table");
`endif

endmodule
`default_nettype wire

/* design/ap_client_association_table_top.sv */
// ap_client_association_table_top: access point table with per-entry client lists
//
//   channel  ports                      handshake
//   input    in_word                    start high while busy low
//   result   out_word                   out_valid strobe, one cycle, no stall
//
// an observe word scans linearly, one entry per cycle through the single read port
// of the access point store and then of the client store; a clear word skips the scans
// synchronous active-low reset empties the table; no clearing pass is needed
// busy stays high from the accepted word to the result strobe
`default_nettype none
module ap_client_association_table_top
  import apcat_pkg::*;
#(
  parameter int AP_ENTRIES     = AP_ENTRIES_DEF,
  parameter int CLIENTS_PER_AP = CPA_DEF
)(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     start,
  output logic          busy,
  input  wire in_word_t in_word,
  output logic          out_valid,
  output out_word_t     out_word
);

  cmd_t cmd;
  sts_t sts;

  apcat_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .sts       (sts),
    .cmd       (cmd),
    .busy      (busy),
    .out_valid (out_valid)
  );

  apcat_dp #(
    .AP_ENTRIES     (AP_ENTRIES),
    .CLIENTS_PER_AP (CLIENTS_PER_AP)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_word  (in_word),
    .cmd      (cmd),
    .sts      (sts),
    .out_word (out_word)
  );

endmodule
`default_nettype wire

/* dv/testbench.sv */
// testbench: directed and random checks of the access point client association table
`default_nettype none
module testbench;
  import apcat_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int AP_N        = AP_ENTRIES_DEF;
  localparam int CL_N        = CPA_DEF;
  localparam int STALL_LIMIT = 3000;
  localparam int SETTLE      = 120;
  localparam logic [ADDR_W-1:0] ADDR_ONES = '1;

  logic      clk;
  logic      rst_n;
  logic      start;
  logic      busy;
  in_word_t  in_word;
  logic      out_valid;
  out_word_t out_word;

  ap_client_association_table_top #(
    .AP_ENTRIES    (AP_N),
    .CLIENTS_PER_AP(CL_N)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_word  (in_word),
    .out_valid(out_valid),
    .out_word (out_word)
  );

  // table image
  logic [ADDR_W-1:0] ap_addr [AP_N];
  logic [ADDR_W-1:0] client_addr [AP_N][CL_N];
  int unsigned       client_cnt [AP_N];
  int unsigned       ap_cnt;

  out_word_t pending_reports [$];
  int        mismatches;
  int        quiet_cycles;
  bit        no_gaps;

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  function automatic logic [ADDR_W-1:0] rand_addr();
    logic [ADDR_W-1:0] a;
    a[31:0]  = $urandom();
    a[47:32] = 16'($urandom_range(0, 16'hFFFF));
    return a;
  endfunction

  function automatic in_word_t mk_word(logic k, logic [ADDR_W-1:0] b, logic p,
                                       logic [ADDR_W-1:0] m);
    in_word_t w;
    w.kind           = k;
    w.bssid          = b;
    w.client_present = p;
    w.client_mac     = m;
    return w;
  endfunction

  function automatic out_word_t assoc_lookup(in_word_t w);
    out_word_t   r;
    int unsigned slot;
    int unsigned n;
    int unsigned i;
    bit          hit;
    bit          dup;
    r    = '0;
    slot = 0;
    hit  = 1'b0;
    dup  = 1'b0;
    if (w.kind == KIND_CLEAR) begin
      ap_cnt = 0;
    end else begin
      for (i = 0; i < ap_cnt; i++) begin
        if (!hit && ap_addr[i] == w.bssid) begin
          slot = i;
          hit  = 1'b1;
        end
      end
      if (!hit) begin
        if (ap_cnt < AP_N) begin
          slot             = ap_cnt;
          ap_addr[slot]    = w.bssid;
          client_cnt[slot] = 0;
          ap_cnt++;
          r.ap_added = 1'b1;
          hit        = 1'b1;
        end else begin
          r.ap_table_full = 1'b1;
        end
      end
      if (hit) begin
        n = client_cnt[slot];
        if (w.client_present) begin
          for (i = 0; i < n; i++) begin
            if (client_addr[slot][i] == w.client_mac) dup = 1'b1;
          end
          if (!dup) begin
            if (n < CL_N) begin
              client_addr[slot][n] = w.client_mac;
              n++;
              r.client_added = 1'b1;
            end else begin
              r.client_list_full = 1'b1;
            end
          end
        end
        client_cnt[slot] = n;
        r.client_total   = n[CTOT_W-1:0];
      end else begin
        slot = 0;
      end
    end
    r.ap_slot  = slot[SLOT_W-1:0];
    r.ap_total = ap_cnt[TOTAL_W-1:0];
    return r;
  endfunction

  task automatic send_word(input in_word_t w);
    @(negedge clk);
    while (!no_gaps && $urandom_range(0, 99) < 8) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start   <= 1'b1;
    in_word <= w;
    do @(posedge clk); while (busy);
    pending_reports.push_back(assoc_lookup(w));
  endtask

  task automatic wait_reports_done();
    @(negedge clk);
    start <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
  endtask

  task automatic check_field(input string name, input longint unsigned want,
                             input longint unsigned got);
    if (want != got) begin
      $display("%0t ns: %s expected %0d got %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    out_word_t want;
    if (rst_n && out_valid) begin
      if (pending_reports.size() == 0) begin
        $display("%0t ns: unexpected word, expected none got %h", $time, out_word);
        mismatches++;
      end else begin
        want = pending_reports.pop_front();
        check_field("ap_slot", want.ap_slot, out_word.ap_slot);
        check_field("ap_added", want.ap_added, out_word.ap_added);
        check_field("client_added", want.client_added, out_word.client_added);
        check_field("ap_table_full", want.ap_table_full, out_word.ap_table_full);
        check_field("client_list_full", want.client_list_full,
                    out_word.client_list_full);
        check_field("ap_total", want.ap_total, out_word.ap_total);
        check_field("client_total", want.client_total, out_word.client_total);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((start && !busy) || out_valid) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  task automatic test_basic_cases();
    logic [ADDR_W-1:0] a5;
    logic [ADDR_W-1:0] aa;
    a5 = {ADDR_W/2{2'b01}};
    aa = {ADDR_W/2{2'b10}};
    send_word(mk_word(KIND_OBSERVE, '0, 1'b0, ADDR_ONES));
    send_word(mk_word(KIND_OBSERVE, ADDR_ONES, 1'b1, '0));
    send_word(mk_word(KIND_OBSERVE, ADDR_ONES, 1'b1, ADDR_ONES));
    send_word(mk_word(KIND_OBSERVE, ADDR_ONES, 1'b1, ADDR_ONES));
    send_word(mk_word(KIND_OBSERVE, '0, 1'b1, a5));
    send_word(mk_word(KIND_OBSERVE, aa, 1'b1, aa));
    send_word(mk_word(KIND_OBSERVE, a5, 1'b1, a5));
    send_word(mk_word(KIND_OBSERVE, '0, 1'b1, a5));
    send_word(mk_word(KIND_OBSERVE, aa, 1'b0, '0));
    send_word(mk_word(KIND_CLEAR, ADDR_ONES, 1'b1, ADDR_ONES));
    send_word(mk_word(KIND_OBSERVE, ADDR_ONES, 1'b1, ADDR_ONES));
    send_word(mk_word(KIND_CLEAR, '0, 1'b0, '0));
    send_word(mk_word(KIND_OBSERVE, '0, 1'b1, '0));
  endtask

  task automatic test_client_list_full();
    logic [ADDR_W-1:0] ap;
    logic [ADDR_W-1:0] first_mac;
    int                k;
    ap        = rand_addr();
    first_mac = rand_addr();
    send_word(mk_word(KIND_OBSERVE, ap, 1'b1, first_mac));
    for (k = 1; k < CL_N + 2; k++) send_word(mk_word(KIND_OBSERVE, ap, 1'b1, rand_addr()));
    send_word(mk_word(KIND_OBSERVE, ap, 1'b1, first_mac));
    send_word(mk_word(KIND_OBSERVE, ap, 1'b0, rand_addr()));
  endtask

  task automatic test_ap_table_full();
    logic [ADDR_W-1:0] first_ap;
    int                k;
    wait_reports_done();
    send_word(mk_word(KIND_CLEAR, rand_addr(), 1'b0, rand_addr()));
    first_ap = rand_addr();
    send_word(mk_word(KIND_OBSERVE, first_ap, 1'b1, rand_addr()));
    for (k = 1; k < AP_N; k++) begin
      send_word(mk_word(KIND_OBSERVE, rand_addr(), 1'($urandom_range(0, 1)), rand_addr()));
    end
    for (k = 0; k < 3; k++) send_word(mk_word(KIND_OBSERVE, rand_addr(), 1'b1, rand_addr()));
    send_word(mk_word(KIND_OBSERVE, rand_addr(), 1'b0, rand_addr()));
    send_word(mk_word(KIND_OBSERVE, first_ap, 1'b1, rand_addr()));
    send_word(mk_word(KIND_CLEAR, rand_addr(), 1'b1, rand_addr()));
  endtask

  task automatic test_random_traffic(input int count);
    logic [ADDR_W-1:0] ap_pool [96];
    logic [ADDR_W-1:0] mac_pool [32];
    int                ap_span;
    int                mac_span;
    int                k;
    int                j;
    in_word_t          w;
    ap_span  = 0;
    mac_span = 0;
    for (k = 0; k < count; k++) begin
      if (k % 250 == 0) begin
        ap_span  = $urandom_range(8, 96);
        mac_span = $urandom_range(4, 32);
        for (j = 0; j < 96; j++) ap_pool[j] = rand_addr();
        for (j = 0; j < 32; j++) mac_pool[j] = rand_addr();
      end
      no_gaps = (k >= 600 && k < 900);
      if (k == 1000) wait_reports_done();
      w = mk_word(KIND_OBSERVE, ap_pool[$urandom_range(0, ap_span - 1)],
                  $urandom_range(0, 99) < 85, mac_pool[$urandom_range(0, mac_span - 1)]);
      if ($urandom_range(0, 99) < 5) w.bssid = rand_addr();
      if ($urandom_range(0, 99) < 10) w.client_mac = rand_addr();
      if ($urandom_range(0, 249) == 0) begin
        w.kind = KIND_CLEAR;
      end
      send_word(w);
    end
    no_gaps = 1'b0;
  endtask

  initial begin
    rst_n        = 1'b0;
    start        = 1'b0;
    in_word      = '0;
    mismatches   = 0;
    quiet_cycles = 0;
    no_gaps      = 1'b0;
    ap_cnt       = 0;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    test_basic_cases();
    test_client_list_full();
    test_ap_table_full();
    test_random_traffic(1750);
    wait_reports_done();
    repeat (SETTLE) @(posedge clk);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
`default_nettype wire
